// ===== src/scdp_pkg.sv =====
// Package for the sparse column dot product block.
// Holds function codes, register indexes, field widths and default sizes.
// No dependencies.
package scdp_pkg;

	// Default store sizes
	localparam int MAX_ROWS_DEF = 256;
	localparam int MAX_COLS_DEF = 256;

	// Field widths
	localparam int FUNC_W  = 2;
	localparam int ADDR_W  = 16;
	localparam int VAL_W   = 16;
	localparam int COL_W   = 8;
	localparam int CFG_W   = 9;
	localparam int CIDX_W  = 2;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int SUM_W   = 40;

	// Function codes of an input word
	localparam logic [FUNC_W-1:0] FUNC_LOAD_WEIGHT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_GRAD   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE     = 2'd2;

	// Register indexes of the configuration port
	localparam logic [CIDX_W-1:0] CFG_ROW_COUNT = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_COL_COUNT = 2'd1;

	// Register reset values
	localparam logic [CFG_W-1:0] ROW_COUNT_RST = 9'd256;
	localparam logic [CFG_W-1:0] COL_COUNT_RST = 9'd256;

endpackage

// ===== src/scdp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module scdp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/sparse_column_dot_product.sv =====
// Top level of the sparse column dot product block.
// Depends on scdp_pkg and scdp_ram (weight and gradient stores).
//
//  channel  dir  handshake            words
//  in       in   in_valid / in_stall  func, load_address, load_value, column_index, last_column
//  out      out  out_valid/ out_stall column_sum, index_error, last
//  cfg      in   cfg_valid/ cfg_ready cfg_index, cfg_data
//
// Load words write a store when taken. For a compute word, one
// multiply-accumulate unit walks the rows, one weight and gradient read a cycle.
// A compute word with zero rows still passes the walk step; a bad column goes
// straight to the finish step. in_stall is high for the whole walk.
// A result waits in the output register under out_stall; load words go on.
// Reset sets row_count and col_count to 256; the stores are not cleared.
module sparse_column_dot_product #(
	parameter int MAX_ROWS = scdp_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = scdp_pkg::MAX_COLS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input words
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [scdp_pkg::FUNC_W-1:0]       func,
	input  logic [scdp_pkg::ADDR_W-1:0]       load_address,
	input  logic signed [scdp_pkg::VAL_W-1:0] load_value,
	input  logic [scdp_pkg::COL_W-1:0]        column_index,
	input  logic                              last_column,
	// result words
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [scdp_pkg::SUM_W-1:0] column_sum,
	output logic                              index_error,
	output logic                              last,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [scdp_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [scdp_pkg::CFG_W-1:0]        cfg_data
);

	localparam longint WDEPTH = longint'(MAX_ROWS) * longint'(MAX_COLS);
	localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int GAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RCNT_W = ($clog2(MAX_ROWS + 1) > scdp_pkg::CFG_W) ?
		$clog2(MAX_ROWS + 1) : scdp_pkg::CFG_W;
	localparam int CCNT_W = ($clog2(MAX_COLS + 1) > scdp_pkg::CFG_W) ?
		$clog2(MAX_COLS + 1) : scdp_pkg::CFG_W;
	localparam int WCMP_W = (WAW + 1 > scdp_pkg::ADDR_W) ? WAW + 1 : scdp_pkg::ADDR_W + 1;
	localparam int GCMP_W = (RCNT_W > scdp_pkg::ADDR_W) ? RCNT_W + 1 : scdp_pkg::ADDR_W + 1;

	// Sequencer states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]                        state_q;
	logic [scdp_pkg::CFG_W-1:0]        row_count_q;
	logic [scdp_pkg::CFG_W-1:0]        col_count_q;
	logic [RCNT_W-1:0]                 rows_eff;
	logic [CCNT_W-1:0]                 cols_eff;
	logic [RCNT_W-1:0]                 rows_q;
	logic [RCNT_W-1:0]                 row_q;
	logic [WAW-1:0]                    step_q;
	logic [WAW-1:0]                    waddr_q;
	logic                              err_q;
	logic                              last_q;
	logic                              in_acc;
	logic                              issue;
	logic                              rd_v_s1;
	logic                              prod_v_s2;
	logic signed [scdp_pkg::PROD_W-1:0] prod_s2;
	logic signed [scdp_pkg::SUM_W-1:0] acc_q;
	logic [scdp_pkg::VAL_W-1:0]        w_rdata;
	logic [scdp_pkg::VAL_W-1:0]        g_rdata;
	logic                              w_we;
	logic                              g_we;
	logic                              out_load;
	logic                              out_take;
	logic                              out_valid_q;
	logic signed [scdp_pkg::SUM_W-1:0] column_sum_q;
	logic                              index_error_q;
	logic                              last_out_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Clamp the registers to the store sizes
	assign rows_eff = (RCNT_W'(row_count_q) > RCNT_W'(MAX_ROWS)) ?
		RCNT_W'(MAX_ROWS) : RCNT_W'(row_count_q);
	assign cols_eff = (CCNT_W'(col_count_q) > CCNT_W'(MAX_COLS)) ?
		CCNT_W'(MAX_COLS) : CCNT_W'(col_count_q);

	// Store writes, dropped when the address is out of range
	assign w_we = in_acc && (func == scdp_pkg::FUNC_LOAD_WEIGHT) &&
		(WCMP_W'(load_address) < WCMP_W'(WDEPTH));
	assign g_we = in_acc && (func == scdp_pkg::FUNC_LOAD_GRAD) &&
		(GCMP_W'(load_address) < GCMP_W'(MAX_ROWS));

	scdp_ram #(
		.WIDTH(scdp_pkg::VAL_W),
		.DEPTH(int'(WDEPTH))
	) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (WAW'(load_address)),
		.wdata (load_value),
		.raddr (waddr_q),
		.rdata (w_rdata)
	);

	scdp_ram #(
		.WIDTH(scdp_pkg::VAL_W),
		.DEPTH(MAX_ROWS)
	) u_grad_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (GAW'(load_address)),
		.wdata (load_value),
		.raddr (row_q[GAW-1:0]),
		.rdata (g_rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= scdp_pkg::ROW_COUNT_RST;
			col_count_q <= scdp_pkg::COL_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				scdp_pkg::CFG_ROW_COUNT: row_count_q <= cfg_data;
				scdp_pkg::CFG_COL_COUNT: col_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign issue    = (state_q == ST_RUN) && (row_q < rows_q);
	assign out_take = out_valid_q && !out_stall;
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	// Sequencer and row walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_v_s1   <= 1'b0;
			prod_v_s2 <= 1'b0;
		end else begin
			rd_v_s1   <= issue;
			prod_v_s2 <= rd_v_s1;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (func == scdp_pkg::FUNC_COMPUTE)) begin
						if (CCNT_W'(column_index) >= cols_eff) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (!issue && !rd_v_s1 && !prod_v_s2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Walk datapath: address step, multiply, accumulate
	always_ff @(posedge clk) begin
		if (in_acc && (func == scdp_pkg::FUNC_COMPUTE)) begin
			rows_q  <= rows_eff;
			row_q   <= '0;
			step_q  <= WAW'(cols_eff);
			waddr_q <= WAW'(column_index);
			err_q   <= (CCNT_W'(column_index) >= cols_eff);
			last_q  <= last_column;
			acc_q   <= '0;
		end else begin
			if (issue) begin
				row_q   <= row_q + RCNT_W'(1);
				waddr_q <= waddr_q + step_q;
			end
			if (prod_v_s2) begin
				acc_q <= acc_q + {{(scdp_pkg::SUM_W - scdp_pkg::PROD_W){prod_s2[scdp_pkg::PROD_W-1]}},
					prod_s2};
			end
		end
		prod_s2 <= $signed(w_rdata) * $signed(g_rdata);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			column_sum_q  <= acc_q;
			index_error_q <= err_q;
			last_out_q    <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign column_sum  = column_sum_q;
	assign index_error = index_error_q;
	assign last        = last_out_q;

	// Pipeline words only live inside the walk
	a_s1_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == ST_RUN))
		else $error("read stage busy outside the walk");

	a_s2_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		prod_v_s2 |-> (state_q == ST_RUN))
		else $error("product stage busy outside the walk");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (row_q <= rows_q))
		else $error("row counter ran past the row count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && index_error) |-> (column_sum == '0))
		else $error("bad column gave a nonzero sum");

	a_load_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result word appeared outside the finish step");

endmodule
